### rtl/adjacency_matrix_graph_store_macros.svh
// assertion macros for the adjacency matrix graph store checker
// no dependencies; included by files that hold concurrent assertions
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_MACROS_SVH

// same-cycle implication
`define AMGS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMGS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/amgs_pkg.sv
// types and constants for the adjacency matrix graph store
// no dependencies; used by the top level and the checker
package amgs_pkg;

  localparam int unsigned VERTICES = 64;
  localparam int unsigned VW       = $clog2(VERTICES);
  localparam int unsigned CW       = $clog2(VERTICES + 1);

  localparam logic [1:0] MODE_ADD_VERTEX = 2'd0;
  localparam logic [1:0] MODE_ADD_EDGE   = 2'd1;
  localparam logic [1:0] MODE_REM_VERTEX = 2'd2;
  localparam logic [1:0] MODE_REM_EDGE   = 2'd3;

  typedef logic [VERTICES-1:0] row_t;
  typedef logic [VW-1:0]       vtx_t;

  typedef struct packed {
    logic [1:0] mode;
    vtx_t       first_vertex;
    vtx_t       second_vertex;
  } in_word_t;

  typedef struct packed {
    logic          applied;
    logic [CW-1:0] vertex_count;
    logic          first_present;
    logic          second_present;
    logic          edge_forward;
    logic          edge_backward;
  } out_word_t;

endpackage

### rtl/adjacency_matrix_graph_store.sv
// adjacency matrix graph store: bit matrix memory, presence bits and vertex count
// depends on amgs_pkg
//
//  port group          dir  handshake
//  start/busy, cmd_i   in   taken when start && !busy
//  cfg_we_i/wdata_i    in   directed flag, written when cfg_we_i
//  result_valid_o/o    out  one-cycle strobe, receiver cannot stall
//
// a word steps from accept through read row a, read row b and result before the next
// possible accept; rows are read-modify-written through one read and one write port
// removing a present vertex instead sweeps every row to clear its column before the
// next possible accept
// reset clears control, presence, count and the row valid bits; invalid rows read zero
module adjacency_matrix_graph_store import amgs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  cmd_i,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output logic      result_valid_o,
  output out_word_t result_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROWA  = 2'd1;
  localparam logic [1:0] ST_ROWB  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [1:0]          mode_q;
  vtx_t                a_q, b_q;
  vtx_t                idx_q, idx_d;
  logic                dir_q;
  logic [VERTICES-1:0] pres_q, pres_new;
  logic [CW-1:0]       cnt_q, cnt_new;
  row_t                row_a_q, row_a_d;
  row_t                mem [VERTICES];
  logic [VERTICES-1:0] row_vld_q;
  row_t                rd_q;
  logic                rd_vld_q;
  logic                res_vld_q;
  out_word_t           res_q, res_d;

  vtx_t  rd_addr, wr_addr;
  logic  mem_we;
  row_t  wr_data;
  row_t  rd_row, row_a_new, row_b_cur, row_b_new, bit_a, bit_b;
  logic  pa, pb, same, set_bit, edge_en, wr_b, sweep_go, finish, applied;

  assign rd_row    = rd_vld_q ? rd_q : '0;
  assign bit_a     = row_t'(1) << a_q;
  assign bit_b     = row_t'(1) << b_q;
  assign pa        = pres_q[a_q];
  assign pb        = pres_q[b_q];
  assign same      = (a_q == b_q);
  assign set_bit   = (mode_q == MODE_ADD_EDGE);
  assign edge_en   = (mode_q == MODE_ADD_EDGE) || ((mode_q == MODE_REM_EDGE) && pa && pb);
  assign wr_b      = edge_en && !dir_q;
  assign sweep_go  = (mode_q == MODE_REM_VERTEX) && pa;
  assign row_a_new = edge_en ? (set_bit ? (rd_row | bit_b) : (rd_row & ~bit_b)) : rd_row;
  assign row_b_cur = same ? row_a_q : rd_row;
  assign row_b_new = wr_b ? (set_bit ? (row_b_cur | bit_a) : (row_b_cur & ~bit_a))
                          : row_b_cur;
  assign finish    = (state_q == ST_ROWB) ||
                     ((state_q == ST_SWEEP) && (idx_q == VW'(VERTICES - 1)));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    row_a_d = row_a_q;
    rd_addr = a_q;
    mem_we  = 1'b0;
    wr_addr = a_q;
    wr_data = row_a_new;
    case (state_q)
      ST_IDLE: begin
        rd_addr = cmd_i.first_vertex;
        if (start) begin
          state_d = ST_ROWA;
        end
      end
      ST_ROWA: begin
        row_a_d = row_a_new;
        mem_we  = edge_en;
        if (sweep_go) begin
          rd_addr = '0;
          idx_d   = '0;
          state_d = ST_SWEEP;
        end else begin
          rd_addr = b_q;
          state_d = ST_ROWB;
        end
      end
      ST_ROWB: begin
        mem_we  = wr_b;
        wr_addr = b_q;
        wr_data = row_b_new;
        state_d = ST_IDLE;
      end
      ST_SWEEP: begin
        rd_addr = idx_q + VW'(1);
        mem_we  = 1'b1;
        wr_addr = idx_q;
        wr_data = (idx_q == a_q) ? '0 : (rd_row & ~bit_a);
        idx_d   = idx_q + VW'(1);
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // presence, count and result at the end of the word
  always_comb begin
    pres_new = pres_q;
    cnt_new  = cnt_q;
    applied  = 1'b0;
    case (mode_q)
      MODE_ADD_VERTEX: begin
        pres_new[a_q] = 1'b1;
        cnt_new       = cnt_q + CW'(!pa);
        applied       = !pa;
      end
      MODE_ADD_EDGE: begin
        pres_new[a_q] = 1'b1;
        pres_new[b_q] = 1'b1;
        cnt_new       = cnt_q + CW'(!pa) + CW'(!pb && !same);
        applied       = 1'b1;
      end
      MODE_REM_VERTEX: begin
        pres_new[a_q] = 1'b0;
        cnt_new       = cnt_q - CW'(pa);
        applied       = pa;
      end
      MODE_REM_EDGE: begin
        applied = pa && pb;
      end
      default: begin
        applied = 1'b0;
      end
    endcase
    res_d.applied        = applied;
    res_d.vertex_count   = cnt_new;
    res_d.first_present  = pres_new[a_q];
    res_d.second_present = pres_new[b_q];
    if (state_q == ST_SWEEP) begin
      res_d.edge_forward  = 1'b0;
      res_d.edge_backward = 1'b0;
    end else begin
      res_d.edge_forward  = same ? row_b_new[b_q] : row_a_q[b_q];
      res_d.edge_backward = row_b_new[a_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dir_q     <= 1'b1;
      pres_q    <= '0;
      cnt_q     <= '0;
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= row_vld_q[rd_addr];
      if (mem_we) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      res_vld_q <= finish;
      if (finish) begin
        pres_q <= pres_new;
        cnt_q  <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    row_a_q <= row_a_d;
    if ((state_q == ST_IDLE) && start) begin
      mode_q <= cmd_i.mode;
      a_q    <= cmd_i.first_vertex;
      b_q    <= cmd_i.second_vertex;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

### rtl/amgs_checker.sv
// port-level checks for the adjacency matrix graph store, bound to the top level
// depends on amgs_pkg and adjacency_matrix_graph_store_macros.svh
`include "adjacency_matrix_graph_store_macros.svh"

module amgs_checker import amgs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      result_valid_o,
  input out_word_t result_o
);

  `AMGS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accept did not raise busy")
  `AMGS_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o, "back-to-back result words")
  `AMGS_ASSERT_NOW(a_count_range, clk_i, rst_ni, result_valid_o, result_o.vertex_count <= CW'(VERTICES), "vertex count out of range")
  `AMGS_ASSERT_NOW(a_edge_present, clk_i, rst_ni, result_valid_o && result_o.edge_forward, result_o.first_present && result_o.second_present, "edge between absent vertices")
  `AMGS_ASSERT_NOW(a_result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy), "result word without work")

endmodule

bind adjacency_matrix_graph_store amgs_checker u_amgs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
